// ===== src/csp_pkg.sv =====
// Shared types and constants for the connection slot pool.
package csp_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONCURRENCY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONNECTIONS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME_SECONDS = 2'd2;

    // Request modes
    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Per-entry status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STALE = 2'd1;
    localparam logic [1:0] ST_DOWN  = 2'd2;

    // Result codes
    localparam logic [2:0] RES_REUSED    = 3'd0;
    localparam logic [2:0] RES_OPENED    = 3'd1;
    localparam logic [2:0] RES_WAIT      = 3'd2;
    localparam logic [2:0] RES_FAILED    = 3'd3;
    localparam logic [2:0] RES_RELEASED  = 3'd4;
    localparam logic [2:0] RES_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [31:0] now;
        logic [15:0] release_id;
        logic        dispose;
        logic        open_ok;
    } csp_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] conn_id;
        logic [7:0]  use_count;
        logic [4:0]  pool_count;
    } csp_out_t;

    typedef struct packed {
        logic [7:0]  max_concurrency;
        logic [4:0]  max_connections;
        logic [15:0] lifetime_seconds;
    } csp_cfg_t;

    localparam csp_cfg_t CFG_RESET = '{
        max_concurrency:  8'd5,
        max_connections:  5'd3,
        lifetime_seconds: 16'd0
    };

    // Verdict of the entry unit on one pool entry
    typedef struct packed {
        logic keep;   // entry survives and is written back
        logic hit;    // entry granted (acquire) or matched (release)
        logic halt;   // nothing further in the pool can change
    } csp_eval_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } csp_state_t;

endpackage

// ===== src/csp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/csp_entry_unit.sv =====
// Per-entry evaluation: ageing, grant check and release update of one pool entry.
module csp_entry_unit #(
    parameter int ID_BITS = 16
) (
    input  logic               mode,
    input  logic [31:0]        now,
    input  logic [15:0]        release_id,
    input  logic               dispose,
    input  logic               age_en,
    input  logic [15:0]        lifetime,
    input  logic [7:0]         max_conc,
    input  logic               already,
    input  logic [ID_BITS-1:0] id_in,
    input  logic [1:0]         status_in,
    input  logic [7:0]         users_in,
    input  logic [31:0]        open_time_in,
    output logic [1:0]         status_out,
    output logic [7:0]         users_out,
    output csp_pkg::csp_eval_t flags
);

    import csp_pkg::*;

    localparam int IDW = (ID_BITS > 16) ? ID_BITS : 16;

    logic [31:0]  age;
    logic         expired;
    logic         drop;
    logic         hit;
    logic [IDW-1:0] id_w;
    logic [IDW-1:0] rel_w;
    logic         id_match;

    always_comb
    begin
        age        = now - open_time_in;
        expired    = age_en && (age > {16'd0, lifetime});
        id_w       = IDW'(id_in);
        rel_w      = IDW'(release_id);
        id_match   = (id_w == rel_w);
        status_out = status_in;
        users_out  = users_in;
        hit        = 1'b0;
        drop       = 1'b0;

        if (mode == MODE_ACQUIRE)
        begin
            if (expired)
            begin
                if (users_in == 8'd0)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    status_out = ST_STALE;
                end
            end
            if (!drop && !already && status_out == ST_OK && users_in < max_conc)
            begin
                hit       = 1'b1;
                users_out = users_in + 8'd1;
            end
        end
        else
        begin
            if (!already && id_match)
            begin
                hit = 1'b1;
                if (users_in != 8'd0)
                begin
                    users_out = users_in - 8'd1;
                end
                if (dispose)
                begin
                    status_out = ST_DOWN;
                end
                drop = (status_out != ST_OK) && (users_out == 8'd0);
            end
        end

        flags.keep = !drop;
        flags.hit  = hit;
        // without ageing an acquire is done at the grant; a release is done
        // at the match unless the entry leaves and the tail must move down
        flags.halt = hit && ((mode == MODE_RELEASE) ? !drop : !age_en);
    end

endmodule

// ===== src/csp_ctrl.sv =====
// Sequencer: walks the pool one entry per cycle, compacts it and forms the result.
module csp_ctrl #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_BITS   = 16,
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int DW = ID_BITS + 42
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  csp_pkg::csp_in_t   req,
    input  csp_pkg::csp_cfg_t  cfg,
    output logic               busy,
    output logic               res_valid,
    output csp_pkg::csp_out_t  res,
    output logic               ram_rd_en,
    output logic [AW-1:0]      ram_rd_addr,
    input  logic [DW-1:0]      ram_rd_data,
    output logic               ram_wr_en,
    output logic [AW-1:0]      ram_wr_addr,
    output logic [DW-1:0]      ram_wr_data
);

    import csp_pkg::*;

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int IDW   = (ID_BITS > 16) ? ID_BITS : 16;

    csp_state_t         state_reg, state_next;
    csp_in_t            item_reg, item_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;
    logic               pend_reg, pend_next;
    logic               hit_reg, hit_next;
    logic [ID_BITS-1:0] hit_id_reg, hit_id_next;
    logic [7:0]         hit_users_reg, hit_users_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_BITS-1:0] next_id_reg, next_id_next;

    logic [ID_BITS-1:0] ent_id;
    logic [1:0]         ent_status;
    logic [7:0]         ent_users;
    logic [31:0]        ent_time;
    logic [1:0]         upd_status;
    logic [7:0]         upd_users;
    csp_eval_t          flags;
    logic               eval_en;
    logic               issue;
    logic               age_en;
    logic               can_open;
    logic [CMP_W-1:0]   cnt_out;
    logic [IDW-1:0]     hit_id_w;
    logic [IDW-1:0]     new_id_w;

    // entry word: {id, status, users, open time}
    assign ent_time   = ram_rd_data[31:0];
    assign ent_users  = ram_rd_data[39:32];
    assign ent_status = ram_rd_data[41:40];
    assign ent_id     = ram_rd_data[DW-1:42];

    assign age_en   = (cfg.lifetime_seconds != 16'd0);
    assign eval_en  = (state_reg == S_SCAN) && pend_reg;
    assign issue    = (state_reg == S_SCAN) && (rd_idx_reg < count_reg)
                      && !(eval_en && flags.halt);
    assign can_open = (CMP_W'(count_reg) < CMP_W'(cfg.max_connections))
                      && (count_reg < CNT_W'(MAX_SLOTS));
    assign hit_id_w = IDW'(hit_id_reg);
    assign new_id_w = IDW'(next_id_reg);
    assign busy     = (state_reg != S_IDLE);

    csp_entry_unit #(
        .ID_BITS (ID_BITS)
    ) u_entry (
        .mode         (item_reg.mode),
        .now          (item_reg.now),
        .release_id   (item_reg.release_id),
        .dispose      (item_reg.dispose),
        .age_en       (age_en),
        .lifetime     (cfg.lifetime_seconds),
        .max_conc     (cfg.max_concurrency),
        .already      (hit_reg),
        .id_in        (ent_id),
        .status_in    (ent_status),
        .users_in     (ent_users),
        .open_time_in (ent_time),
        .status_out   (upd_status),
        .users_out    (upd_users),
        .flags        (flags)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        hit_id_next    = hit_id_reg;
        hit_users_next = hit_users_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = rd_idx_reg[AW-1:0];
        ram_wr_en      = 1'b0;
        ram_wr_addr    = wr_idx_reg[AW-1:0];
        ram_wr_data    = {ent_id, upd_status, upd_users, ent_time};
        res_valid      = 1'b0;
        res            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = req;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                end
            end
            S_SCAN:
            begin
                // read slot rd_idx while the previous slot is judged and
                // written down to wr_idx (wr_idx trails, so no clash)
                ram_rd_en   = issue;
                rd_idx_next = rd_idx_reg + CNT_W'(issue);
                pend_next   = issue;
                if (eval_en)
                begin
                    if (flags.keep)
                    begin
                        ram_wr_en   = 1'b1;
                        wr_idx_next = wr_idx_reg + CNT_W'(1);
                    end
                    if (flags.hit)
                    begin
                        hit_next       = 1'b1;
                        hit_id_next    = ent_id;
                        hit_users_next = upd_users;
                    end
                end
                if (!issue)
                begin
                    // an early stop leaves the tail untouched
                    count_next = (eval_en && flags.halt) ? count_reg : wr_idx_next;
                end
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (item_reg.mode == MODE_ACQUIRE)
                begin
                    if (hit_reg)
                    begin
                        res.status    = RES_REUSED;
                        res.conn_id   = hit_id_w[15:0];
                        res.use_count = hit_users_reg;
                    end
                    else if (can_open)
                    begin
                        if (item_reg.open_ok)
                        begin
                            ram_wr_en     = 1'b1;
                            ram_wr_addr   = count_reg[AW-1:0];
                            ram_wr_data   = {next_id_reg, ST_OK, 8'd1, item_reg.now};
                            count_next    = count_reg + CNT_W'(1);
                            next_id_next  = next_id_reg + ID_BITS'(1);
                            res.status    = RES_OPENED;
                            res.conn_id   = new_id_w[15:0];
                            res.use_count = 8'd1;
                        end
                        else
                        begin
                            res.status = RES_FAILED;
                        end
                    end
                    else
                    begin
                        res.status = RES_WAIT;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        res.status    = RES_RELEASED;
                        res.conn_id   = hit_id_w[15:0];
                        res.use_count = hit_users_reg;
                    end
                    else
                    begin
                        res.status  = RES_NOT_FOUND;
                        res.conn_id = item_reg.release_id;
                    end
                end
            end
            default:
            begin
            end
        endcase

        cnt_out        = CMP_W'(count_next);
        res.pool_count = cnt_out[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            count_reg   <= '0;
            next_id_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            wr_idx_reg  <= wr_idx_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        hit_id_reg    <= hit_id_next;
        hit_users_reg <= hit_users_next;
    end

    a_wr_trails_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= rd_idx_reg)
        else $error("compaction write index passed read index");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SLOTS))
        else $error("pool count above slot capacity");

    a_ram_ports_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("slot RAM read and write collide");

    a_finish_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> (state_reg == S_IDLE))
        else $error("result stage held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

endmodule

// ===== src/connection_slot_pool.sv =====
// Connection slot pool top level: configuration registers, slot RAM, sequencer, result register.
//
// Each request is taken when start is high and busy is low. The sequencer reads the pool
// one entry per cycle from a single slot RAM (registered read), ages, grants or releases
// it and writes survivors back down in place, so removal compacts the pool in the same
// pass. An item holds busy while the entries are walked (all of them for an acquire with
// ageing on or a release whose entry leaves, else up to the grant or match; at most
// MAX_SLOTS) and its result is formed; the result appears on result with done high for
// one cycle as busy falls, and a new item may start in that cycle. The receiver cannot stall.
// No clearing pass is needed after reset.
module connection_slot_pool #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  csp_pkg::csp_in_t                    req,
    output logic                                busy,
    output logic                                done,
    output csp_pkg::csp_out_t                   result,
    input  logic                                cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import csp_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int DW = ID_BITS + 42;

    csp_cfg_t  cfg_reg, cfg_next;
    logic      done_reg;
    csp_out_t  result_reg;

    logic          res_valid;
    csp_out_t      res;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DW-1:0] ram_rd_data;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_CONCURRENCY:  cfg_next.max_concurrency  = cfg_data[7:0];
                CFG_MAX_CONNECTIONS:  cfg_next.max_connections  = cfg_data[4:0];
                CFG_LIFETIME_SECONDS: cfg_next.lifetime_seconds = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= CFG_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= res;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    csp_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .cfg         (cfg_reg),
        .busy        (busy),
        .res_valid   (res_valid),
        .res         (res),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    csp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule
